// ===== hdl/loop_timing_monitor_top_macros.svh =====
// Assertion macros for the loop timing monitor.
`ifndef LOOP_TIMING_MONITOR_TOP_MACROS_SVH
`define LOOP_TIMING_MONITOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LTM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("loop timing monitor check failed");
`define LTM_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("loop timing monitor forbidden condition");
`else
`define LTM_ASSERT(lbl, clk, rstn, prop)
`define LTM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hdl/ltm_pkg.sv =====
// ----------------------------------------------------------------------------
// Loop timing monitor package
// Beat types, event codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ltm_pkg;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_BEGIN   = 3'd1;
    localparam logic [2:0] MODE_END     = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;
    localparam logic [2:0] MODE_OBSERVE = 3'd5;

    localparam logic REG_FREQ   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] stamp;
    } evt_t;

    typedef struct packed {
        logic        pending;
        logic [31:0] last_lat_us;
        logic [31:0] latency_max_us;
        logic [31:0] exec_us;
        logic [31:0] exec_max_us;
        logic [31:0] loops;
        logic [31:0] overruns;
        logic [63:0] exec_sum_us;
        logic [31:0] deadline_left_us;
    } res_t;

    typedef struct packed {
        logic [11:0] freq_mhz;
        logic [31:0] period_usec;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/ltm_div.sv =====
// ----------------------------------------------------------------------------
// Loop timing monitor divider
// Restoring divider, one quotient bit per cycle, shared by all span conversions.
// ----------------------------------------------------------------------------
`default_nettype none

module ltm_div
    import ltm_pkg::*;
#(
    parameter int SW = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [SW-1:0] dividend,
    input  wire logic [11:0]   divisor,
    output logic               done,
    output logic [SW-1:0]      quotient
);

    localparam int CW = $clog2(SW + 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [SW-1:0] dvd_reg;
    logic [SW-1:0] dvd_next;
    logic [11:0]   rem_reg;
    logic [11:0]   rem_next;
    logic [12:0]   shifted;
    logic [13:0]   trial;

    assign shifted = {rem_reg, dvd_reg[SW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SW);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (trial[13])
            begin
                rem_next = shifted[11:0];
                dvd_next = {dvd_reg[SW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[11:0];
                dvd_next = {dvd_reg[SW-2:0], 1'b1};
            end
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/ltm_core.sv =====
// ----------------------------------------------------------------------------
// Loop timing monitor core
// Event sequencer and diagnostic state, driving the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ltm_core
    import ltm_pkg::*;
#(
    parameter int SW = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic evt_valid,
    output logic      evt_stall,
    input  wire evt_t evt,
    input  wire logic res_ready,
    output logic      res_go,
    output res_t      res_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SPAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_LEFT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [2:0]    mode_reg;
    logic [2:0]    mode_next;
    logic [SW-1:0] stamp_reg;
    logic [SW-1:0] stamp_next;
    logic [SW-1:0] tick_stamp_reg;
    logic [SW-1:0] tick_stamp_next;
    logic [SW-1:0] begin_stamp_reg;
    logic [SW-1:0] begin_stamp_next;
    logic          pend_reg;
    logic          pend_next;
    logic          seen_reg;
    logic          seen_next;
    logic [31:0]   lat_reg;
    logic [31:0]   lat_next;
    logic [31:0]   lat_max_reg;
    logic [31:0]   lat_max_next;
    logic [31:0]   exe_reg;
    logic [31:0]   exe_next;
    logic [31:0]   exe_max_reg;
    logic [31:0]   exe_max_next;
    logic [31:0]   loops_reg;
    logic [31:0]   loops_next;
    logic [31:0]   ovr_reg;
    logic [31:0]   ovr_next;
    logic [63:0]   sum_reg;
    logic [63:0]   sum_next;
    logic [31:0]   left_reg;
    logic [31:0]   left_next;
    logic          start_reg;
    logic          start_next;
    logic [SW-1:0] dvd_reg;
    logic [SW-1:0] dvd_next;

    logic          div_done;
    logic [SW-1:0] div_quo;
    logic [63:0]   stamp_wide;
    logic [SW-1:0] stamp_in;
    logic [31:0]   span_us;
    logic [SW-1:0] left_from;

    function automatic logic [31:0] sat32(input logic [SW-1:0] q);
        logic [63:0] w;
        w = 64'(q);
        return (w[63:32] != 32'd0) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    assign stamp_wide = {32'd0, evt.stamp};
    assign stamp_in   = stamp_wide[SW-1:0];
    assign span_us    = (cfg.freq_mhz == 12'd0) ? 32'd0 : sat32(div_quo);
    assign left_from  = (mode_reg == MODE_TICK) ? stamp_reg : tick_stamp_reg;

    ltm_div #(
        .SW(SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dvd_reg),
        .divisor  (cfg.freq_mhz),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        stamp_next       = stamp_reg;
        tick_stamp_next  = tick_stamp_reg;
        begin_stamp_next = begin_stamp_reg;
        pend_next        = pend_reg;
        seen_next        = seen_reg;
        lat_next         = lat_reg;
        lat_max_next     = lat_max_reg;
        exe_next         = exe_reg;
        exe_max_next     = exe_max_reg;
        loops_next       = loops_reg;
        ovr_next         = ovr_reg;
        sum_next         = sum_reg;
        left_next        = left_reg;
        start_next       = 1'b0;
        dvd_next         = dvd_reg;
        res_go           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    mode_next  = evt.mode;
                    stamp_next = stamp_in;
                    if (evt.mode == MODE_BEGIN)
                    begin
                        dvd_next   = stamp_in - tick_stamp_reg;
                        start_next = 1'b1;
                        state_next = S_SPAN;
                    end
                    else if (evt.mode == MODE_END)
                    begin
                        dvd_next   = stamp_in - begin_stamp_reg;
                        start_next = 1'b1;
                        state_next = S_SPAN;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_SPAN:
            begin
                if (div_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                case (mode_reg)
                    MODE_TICK:
                    begin
                        tick_stamp_next = stamp_reg;
                        seen_next       = 1'b1;
                        pend_next       = 1'b1;
                    end
                    MODE_BEGIN:
                    begin
                        begin_stamp_next = stamp_reg;
                        pend_next        = 1'b0;
                        lat_next         = span_us;
                        if (span_us > lat_max_reg)
                        begin
                            lat_max_next = span_us;
                        end
                    end
                    MODE_END:
                    begin
                        exe_next   = span_us;
                        loops_next = loops_reg + 32'd1;
                        sum_next   = sum_reg + 64'(span_us);
                        if (span_us > exe_max_reg)
                        begin
                            exe_max_next = span_us;
                        end
                        if (span_us > cfg.period_usec)
                        begin
                            ovr_next = ovr_reg + 32'd1;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        lat_next     = '0;
                        lat_max_next = '0;
                        exe_next     = '0;
                        exe_max_next = '0;
                        loops_next   = '0;
                        ovr_next     = '0;
                        sum_next     = '0;
                    end
                    MODE_STOP:
                    begin
                        pend_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                if (cfg.period_usec != 32'd0 && cfg.freq_mhz != 12'd0 &&
                    (seen_reg || mode_reg == MODE_TICK))
                begin
                    dvd_next   = stamp_reg - left_from;
                    start_next = 1'b1;
                    state_next = S_LEFT;
                end
                else
                begin
                    left_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_LEFT:
            begin
                if (div_done)
                begin
                    left_next  = (span_us < cfg.period_usec) ? cfg.period_usec - span_us : 32'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    res_go     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_reg       <= 1'b0;
            tick_stamp_reg  <= '0;
            begin_stamp_reg <= '0;
            pend_reg        <= 1'b0;
            seen_reg        <= 1'b0;
            lat_reg         <= '0;
            lat_max_reg     <= '0;
            exe_reg         <= '0;
            exe_max_reg     <= '0;
            loops_reg       <= '0;
            ovr_reg         <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            tick_stamp_reg  <= tick_stamp_next;
            begin_stamp_reg <= begin_stamp_next;
            pend_reg        <= pend_next;
            seen_reg        <= seen_next;
            lat_reg         <= lat_next;
            lat_max_reg     <= lat_max_next;
            exe_reg         <= exe_next;
            exe_max_reg     <= exe_max_next;
            loops_reg       <= loops_next;
            ovr_reg         <= ovr_next;
            sum_reg         <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        stamp_reg <= stamp_next;
        left_reg  <= left_next;
        dvd_reg   <= dvd_next;
    end

    assign evt_stall = (state_reg != S_IDLE);

    always_comb
    begin
        res_data.pending          = pend_reg;
        res_data.last_lat_us      = lat_reg;
        res_data.latency_max_us   = lat_max_reg;
        res_data.exec_us          = exe_reg;
        res_data.exec_max_us      = exe_max_reg;
        res_data.loops            = loops_reg;
        res_data.overruns         = ovr_reg;
        res_data.exec_sum_us      = sum_reg;
        res_data.deadline_left_us = left_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/loop_timing_monitor_top.sv =====
// ----------------------------------------------------------------------------
// Loop timing monitor
// Register port, result register and sequencer core of the loop timing monitor.
// ----------------------------------------------------------------------------
// Each event beat produces one result beat carrying all loop diagnostics after
// the event is applied. A begin or end event runs one or two divisions before
// its result beat and other events at most one, because every conversion from
// cycles to microseconds runs through one shared restoring divider that retires
// one quotient bit per cycle. The core takes a new event in the cycle after the
// previous one has been handed to the result register, which may still hold a
// beat waiting for the consumer.
// Registers: cpu_freq_mhz at byte address 0, the control period in
// microseconds at byte address 4; write them only while the block is idle.
`default_nettype none

`include "loop_timing_monitor_top_macros.svh"

module loop_timing_monitor_top
    import ltm_pkg::*;
#(
    parameter int STAMP_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        evt_valid,
    output logic             evt_stall,
    input  wire evt_t        evt,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_t             res
);

    logic [11:0] freq_reg;
    logic [11:0] freq_next;
    logic [31:0] period_reg;
    logic [31:0] period_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    res_t        res_reg;
    res_t        res_next;

    cfg_t cfg;
    logic cfg_write;
    logic res_ready;
    logic res_go;
    res_t res_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        freq_next   = freq_reg;
        period_next = period_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_FREQ:   freq_next   = pwdata[11:0];
                REG_PERIOD: period_next = pwdata;
                default:    freq_next   = freq_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FREQ:   prdata = {20'd0, freq_reg};
            REG_PERIOD: prdata = period_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.freq_mhz    = freq_reg;
    assign cfg.period_usec = period_reg;

    ltm_core #(
        .SW(STAMP_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_ready (res_ready),
        .res_go    (res_go),
        .res_data  (res_data)
    );

    assign res_ready = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_go)
        begin
            res_valid_next = 1'b1;
            res_next       = res_data;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= '0;
            period_reg    <= PERIOD_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            freq_reg      <= freq_next;
            period_reg    <= period_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `LTM_ASSERT(a_go_needs_room, clk, rst_n, res_go |-> res_ready)
    `LTM_ASSERT(a_accept_then_busy, clk, rst_n, (evt_valid && !evt_stall) |=> evt_stall)
    `LTM_ASSERT(a_go_then_idle, clk, rst_n, res_go |=> !evt_stall)
    `LTM_ASSERT_NEVER(a_go_with_accept, clk, rst_n, res_go && evt_valid && !evt_stall)

endmodule

`default_nettype wire
